FILE: sv/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types, codes and constants of the text console cell writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

	localparam int DEF_CELL_COUNT = 2048;
	localparam int DEF_TAB_SPACES = 4;
	localparam int QUEUE_DEPTH    = 2;

	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int COLR_W = 4;
	localparam int CELL_W = 16;
	localparam int CHAR_W = 8;
	localparam int ADDR_W = 11;
	localparam int IDX_W  = 12;   // holds any col + row * columns
	localparam int CNT_W  = 7;    // glyphs left in a tab or newline run
	localparam int CFG_W  = 7;

	localparam logic [1:0] ACT_PUT   = 2'd0;
	localparam logic [1:0] ACT_CLEAR = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0a;
	localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0d;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

	localparam logic [COL_W-1:0]  RST_COLUMNS = 7'd80;
	localparam logic [ROW_W-1:0]  RST_ROWS    = 5'd25;
	localparam logic [COLR_W-1:0] RST_FORE    = 4'd7;
	localparam logic [COLR_W-1:0] RST_BACK    = 4'd0;

	typedef enum logic [1:0] {
		REG_COLUMNS,
		REG_ROWS,
		REG_FORE,
		REG_BACK
	} reg_idx_t;

	typedef enum logic [2:0] {
		CMD_GLYPH,
		CMD_TAB,
		CMD_CR,
		CMD_NL,
		CMD_CLEAR,
		CMD_READ,
		CMD_NOP
	} cmd_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GLYPH,
		ST_SC_RD,
		ST_SC_WR,
		ST_BLANK,
		ST_FILL,
		ST_RD_WAIT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [CHAR_W-1:0] char_code;
		logic [ADDR_W-1:0] cell_address;
	} in_t;

	typedef struct packed {
		logic [ADDR_W-1:0] cursor_pos;
		logic [COL_W-1:0]  cursor_col;
		logic [ROW_W-1:0]  cursor_row;
		logic [CELL_W-1:0] read_cell;
	} out_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [CHAR_W-1:0] ch;
		logic [ADDR_W-1:0] addr;
	} cmd_t;

endpackage

FILE: sv/tccw_ram.sv
// ----------------------------------------------------------------------------
// tccw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tccw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sv/tccw_front.sv
// ----------------------------------------------------------------------------
// tccw_front
// Accepts input items, classifies them into commands and queues them
// for the back end.
// ----------------------------------------------------------------------------
module tccw_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  tccw_pkg::in_t  in_item,
	input  logic           q_pop,
	output logic           q_valid,
	output tccw_pkg::cmd_t q_cmd
);
	import tccw_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	cmd_t            slot_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            push;
	cmd_t            cmd_in;

	function automatic cmd_kind_t classify(input in_t it);
		cmd_kind_t k;
		k = CMD_NOP;
		case (it.action)
			ACT_PUT: begin
				if (it.char_code == CHAR_TAB)
					k = CMD_TAB;
				else if (it.char_code == CHAR_CR)
					k = CMD_CR;
				else if (it.char_code == CHAR_LF)
					k = CMD_NL;
				else
					k = CMD_GLYPH;
			end
			ACT_CLEAR: k = CMD_CLEAR;
			ACT_READ:  k = CMD_READ;
			default:   k = CMD_NOP;
		endcase
		return k;
	endfunction

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign in_stall = (count_q == CW'(QUEUE_DEPTH));
	assign q_valid  = (count_q != '0);
	assign push     = in_valid && !in_stall;
	assign q_cmd    = slot_q[rd_ptr_q];

	always_comb begin
		cmd_in.kind = classify(in_item);
		cmd_in.ch   = in_item.char_code;
		cmd_in.addr = in_item.cell_address;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (q_pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			case ({push, q_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= cmd_in;
	end

endmodule

FILE: sv/tccw_back.sv
// ----------------------------------------------------------------------------
// tccw_back
// Carries out queued commands: cursor, configuration registers, the cell
// memory walks for scroll and clear, and the result register.
// ----------------------------------------------------------------------------
module tccw_back #(
	parameter int CELL_COUNT = tccw_pkg::DEF_CELL_COUNT,
	parameter int TAB_SPACES = tccw_pkg::DEF_TAB_SPACES
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [tccw_pkg::CFG_W-1:0] cfg_data,
	input  logic                      q_valid,
	input  tccw_pkg::cmd_t            q_cmd,
	output logic                      q_pop,
	output logic                      out_valid,
	input  logic                      out_stall,
	output tccw_pkg::out_t            out_item
);
	import tccw_pkg::*;

	localparam int AW = $clog2(CELL_COUNT);

	state_t              state_q, state_d, disp_state;
	logic [COL_W-1:0]    cols_q, col_q, eff_w;
	logic [ROW_W-1:0]    rows_q, row_q, eff_h;
	logic [COLR_W-1:0]   fore_q, back_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CHAR_W-1:0]   ch_q;
	logic [IDX_W-1:0]    i_q, end_q, blank_end_q;
	logic                src_ok_q;
	logic [CELL_W-1:0]   rd_q;
	logic                out_valid_q;
	out_t                out_item_q;

	logic [IDX_W-1:0]    cur_idx, scroll_lim, screen_cells, src_idx, i_inc;
	logic                wrap, last_row, nl_fits, out_free, dispatch, out_load;
	logic                read_ok, src_in_range;
	logic [CELL_W-1:0]   glyph_word, blank_word;

	logic                ram_we, ram_re;
	logic [IDX_W-1:0]    ram_widx, ram_ridx;
	logic [CELL_W-1:0]   ram_wdata, ram_q;

	assign eff_w = (cols_q == '0) ? COL_W'(1) : cols_q;
	assign eff_h = (rows_q == '0) ? ROW_W'(1) : rows_q;

	assign cur_idx      = IDX_W'(col_q) + IDX_W'(row_q) * IDX_W'(eff_w);
	assign scroll_lim   = IDX_W'(eff_h - ROW_W'(1)) * IDX_W'(eff_w);
	assign screen_cells = IDX_W'(eff_h) * IDX_W'(eff_w);
	assign src_idx      = i_q + IDX_W'(eff_w);
	assign i_inc        = i_q + IDX_W'(1);

	assign wrap     = ({1'b0, col_q} + 8'd1) >= {1'b0, eff_w};
	assign last_row = ({1'b0, row_q} + 6'd1) >= {1'b0, eff_h};
	assign nl_fits  = col_q < eff_w;

	assign read_ok      = 32'(q_cmd.addr) < CELL_COUNT;
	assign src_in_range = 32'(src_idx) < CELL_COUNT;

	assign glyph_word = {back_q, fore_q, ch_q};
	assign blank_word = {back_q, fore_q, CHAR_SPACE};

	assign out_free = !out_valid_q || !out_stall;
	assign dispatch = q_valid && ((state_q == ST_IDLE) || ((state_q == ST_DONE) && out_free));
	assign out_load = (state_q == ST_DONE) && out_free;
	assign q_pop    = dispatch;

	always_comb begin
		case (q_cmd.kind)
			CMD_GLYPH, CMD_TAB: disp_state = ST_GLYPH;
			CMD_NL:             disp_state = nl_fits ? ST_GLYPH : ST_DONE;
			CMD_CLEAR:          disp_state = ST_FILL;
			CMD_READ:           disp_state = ST_RD_WAIT;
			default:            disp_state = ST_DONE;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid)
					state_d = disp_state;
			end
			ST_GLYPH: begin
				if (wrap && last_row)
					state_d = (scroll_lim == '0) ? ST_BLANK : ST_SC_RD;
				else if (cnt_q == CNT_W'(1))
					state_d = ST_DONE;
			end
			ST_SC_RD: state_d = ST_SC_WR;
			ST_SC_WR: state_d = (i_inc == end_q) ? ST_BLANK : ST_SC_RD;
			ST_BLANK: begin
				if (i_inc == blank_end_q)
					state_d = (cnt_q != '0) ? ST_GLYPH : ST_DONE;
			end
			ST_FILL: begin
				if (i_inc == end_q)
					state_d = ST_DONE;
			end
			ST_RD_WAIT: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free)
					state_d = q_valid ? disp_state : ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		ram_we    = 1'b0;
		ram_widx  = i_q;
		ram_wdata = blank_word;
		ram_re    = 1'b0;
		ram_ridx  = src_idx;
		case (state_q)
			ST_GLYPH: begin
				ram_widx  = cur_idx;
				ram_wdata = glyph_word;
				ram_we    = 32'(cur_idx) < CELL_COUNT;
			end
			ST_SC_RD: begin
				ram_re = src_in_range;
			end
			ST_SC_WR: begin
				ram_wdata = src_ok_q ? ram_q : '0;
				ram_we    = 32'(i_q) < CELL_COUNT;
			end
			ST_BLANK, ST_FILL: begin
				ram_we = 32'(i_q) < CELL_COUNT;
			end
			default: begin
				if (dispatch && (q_cmd.kind == CMD_READ)) begin
					ram_re   = read_ok;
					ram_ridx = IDX_W'(q_cmd.addr);
				end
			end
		endcase
	end

	tccw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELL_COUNT)
	) u_cells (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(ram_widx)),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(AW'(ram_ridx)),
		.rdata(ram_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			col_q       <= '0;
			row_q       <= '0;
			cols_q      <= RST_COLUMNS;
			rows_q      <= RST_ROWS;
			fore_q      <= RST_FORE;
			back_q      <= RST_BACK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					REG_COLUMNS: cols_q <= cfg_data;
					REG_ROWS:    rows_q <= cfg_data[ROW_W-1:0];
					REG_FORE:    fore_q <= cfg_data[COLR_W-1:0];
					REG_BACK:    back_q <= cfg_data[COLR_W-1:0];
					default:     cols_q <= cols_q;
				endcase
			end
			if (dispatch) begin
				case (q_cmd.kind)
					CMD_CR: col_q <= '0;
					CMD_CLEAR: begin
						col_q <= '0;
						row_q <= '0;
					end
					default: col_q <= col_q;
				endcase
			end
			if (state_q == ST_GLYPH) begin
				if (wrap) begin
					col_q <= '0;
					if (last_row)
						row_q <= eff_h - ROW_W'(1);
					else
						row_q <= row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dispatch) begin
			rd_q <= '0;
			case (q_cmd.kind)
				CMD_GLYPH: begin
					cnt_q <= CNT_W'(1);
					ch_q  <= q_cmd.ch;
				end
				CMD_TAB: begin
					cnt_q <= CNT_W'(TAB_SPACES);
					ch_q  <= CHAR_SPACE;
				end
				CMD_NL: begin
					cnt_q <= CNT_W'(eff_w - col_q);
					ch_q  <= CHAR_SPACE;
				end
				CMD_CLEAR: begin
					i_q   <= '0;
					end_q <= screen_cells;
				end
				CMD_READ: src_ok_q <= read_ok;
				default: ch_q <= ch_q;
			endcase
		end
		case (state_q)
			ST_GLYPH: begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (wrap && last_row) begin
					i_q         <= '0;
					end_q       <= scroll_lim;
					blank_end_q <= scroll_lim + IDX_W'(eff_w);
				end
			end
			ST_SC_RD:                    src_ok_q <= src_in_range;
			ST_SC_WR, ST_BLANK, ST_FILL: i_q <= i_inc;
			ST_RD_WAIT:                  rd_q <= src_ok_q ? ram_q : '0;
			default: ;
		endcase
		if (out_load) begin
			out_item_q.cursor_pos <= cur_idx[ADDR_W-1:0];
			out_item_q.cursor_col <= col_q;
			out_item_q.cursor_row <= row_q;
			out_item_q.read_cell  <= rd_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

FILE: sv/text_console_cell_writer_top.sv
// Each item runs to its result before the back end takes the next; the front queue holds QUEUE_DEPTH items.
// Work per item: a byte writes one cell, a tab TAB_SPACES spaces, a newline spaces to the row end,
//   a clear columns*rows cells; a scroll copies (rows-1)*columns cells and blanks one row.
// Rate is set by the back-end sequencer: one cell write per cycle; the scroll copy reads each cell
//   and then writes it, since read data is registered; a stalled result holds it.
// Reset: cursor home, registers 80x25 colors 7/0, queue and result empty; cells not cleared.
// ----------------------------------------------------------------------------
// text_console_cell_writer_top
// Text console engine: front end classifies and queues items, back end
// updates cursor and cell memory and returns one result per item.
// ----------------------------------------------------------------------------
module text_console_cell_writer_top #(
	parameter int CELL_COUNT = tccw_pkg::DEF_CELL_COUNT,
	parameter int TAB_SPACES = tccw_pkg::DEF_TAB_SPACES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [tccw_pkg::CFG_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  tccw_pkg::in_t              in_item,
	output logic                       out_valid,
	input  logic                       out_stall,
	output tccw_pkg::out_t             out_item
);
	import tccw_pkg::*;

	logic q_valid, q_pop;
	cmd_t q_cmd;

	tccw_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item (in_item),
		.q_pop   (q_pop),
		.q_valid (q_valid),
		.q_cmd   (q_cmd)
	);

	tccw_back #(
		.CELL_COUNT(CELL_COUNT),
		.TAB_SPACES(TAB_SPACES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_pop    (q_pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item)
	);

	// back end never pops an empty queue
	a_pop_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");

	// an empty queue stays empty unless an item was taken in
	a_empty_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!q_valid && !(in_valid && !in_stall)) |=> !q_valid)
		else $error("queue filled without an accepted item");

	// a full queue always offers a command
	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> q_valid)
		else $error("queue stalls input while empty");

endmodule
